// ----- hdl/sse_vlb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_vlb_pkg
// Shared types and constants of the vertex link builder.
// ----------------------------------------------------------------------------
package sse_vlb_pkg;

  localparam int OPW      = 2;
  localparam int CODEW    = 4;
  localparam int SITEW    = 8;
  localparam int LEGAW    = 13;
  localparam int CNTW     = 11;
  localparam int ENTW     = 14;
  localparam int LEG_BITS = 3;   // eight legs per slice

  typedef enum logic [OPW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic take;
    logic sweep;
    logic site_rd;
    logic site_upd;
    logic link_rd;
    logic link_wr;
    logic link_sel;
    logic read_rd;
    logic next_site;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic nonnull;
    logic site_ok;
    logic last_site;
    logic visited;
    logic sweep_last;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ----- hdl/sse_vlb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_vlb_if
// Request and response channels of the vertex link builder.
// ----------------------------------------------------------------------------
interface sse_vlb_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [sse_vlb_pkg::OPW-1:0]          operation;
  logic signed [sse_vlb_pkg::CODEW-1:0] op_code;
  logic [sse_vlb_pkg::SITEW-1:0]        site_a;
  logic [sse_vlb_pkg::SITEW-1:0]        site_b;
  logic [sse_vlb_pkg::SITEW-1:0]        site_c;
  logic [sse_vlb_pkg::SITEW-1:0]        site_d;
  logic [sse_vlb_pkg::LEGAW-1:0]        leg_address;

  modport source (output valid, operation, op_code, site_a, site_b, site_c, site_d,
                  leg_address, input ready);
  modport sink   (input valid, operation, op_code, site_a, site_b, site_c, site_d,
                  leg_address, output ready);
endinterface

interface sse_vlb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sse_vlb_pkg::LEGAW-1:0] link_leg;
  logic                          link_present;
  logic [sse_vlb_pkg::CNTW-1:0]  slices_seen;
  logic [sse_vlb_pkg::CNTW-1:0]  nonnull_count;
  logic [sse_vlb_pkg::ENTW-1:0]  link_entries;
  logic                          status;

  modport source (output valid, link_leg, link_present, slices_seen, nonnull_count,
                  link_entries, status, input ready);
  modport sink   (input valid, link_leg, link_present, slices_seen, nonnull_count,
                  link_entries, status, output ready);
endinterface
`default_nettype wire

// ----- hdl/sse_vlb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_vlb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sse_vlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sse_vlb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_vlb_ctrl
// Sequencer of the vertex link builder: steps the datapath through sweeps,
// site visits, link read-modify-writes and the response.
// ----------------------------------------------------------------------------
module sse_vlb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire sse_vlb_pkg::stat_t stat,
  output sse_vlb_pkg::cmd_t       cmd
);
  import sse_vlb_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_SWEEP    = 10'b00_0000_0100,
    S_SITE_RD  = 10'b00_0000_1000,
    S_SITE_CHK = 10'b00_0001_0000,
    S_LRD_A    = 10'b00_0010_0000,
    S_LWR_A    = 10'b00_0100_0000,
    S_LRD_B    = 10'b00_1000_0000,
    S_LWR_B    = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (req_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_CLEAR:  state_next = S_FINISH;
          OP_APPEND: state_next = (stat.full || !stat.nonnull) ? S_FINISH : S_SITE_RD;
          OP_CLOSE:  state_next = S_SITE_RD;
          OP_READ: begin
            cmd.read_rd = 1'b1;
            state_next  = S_FINISH;
          end
          default:   state_next = S_FINISH;
        endcase
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_SITE_RD: begin
        if (!stat.site_ok) begin
          // skip a site beyond the lattice
          if (stat.last_site) state_next = S_FINISH;
          else cmd.next_site = 1'b1;
        end else begin
          cmd.site_rd = 1'b1;
          state_next  = S_SITE_CHK;
        end
      end
      S_SITE_CHK: begin
        cmd.site_upd = 1'b1;
        if (stat.visited) begin
          state_next = S_LRD_A;
        end else if (stat.last_site) begin
          state_next = S_FINISH;
        end else begin
          cmd.next_site = 1'b1;
          state_next    = S_SITE_RD;
        end
      end
      S_LRD_A: begin
        cmd.link_rd = 1'b1;
        state_next  = S_LWR_A;
      end
      S_LWR_A: begin
        cmd.link_wr = 1'b1;
        state_next  = S_LRD_B;
      end
      S_LRD_B: begin
        cmd.link_rd  = 1'b1;
        cmd.link_sel = 1'b1;
        state_next   = S_LWR_B;
      end
      S_LWR_B: begin
        cmd.link_wr  = 1'b1;
        cmd.link_sel = 1'b1;
        if (stat.last_site) begin
          state_next = S_FINISH;
        end else begin
          cmd.next_site = 1'b1;
          state_next    = S_SITE_RD;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = (stat.op == OP_CLEAR) ? S_SWEEP : S_IDLE;
        end
      end
      default: state_next = S_SWEEP;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/sse_vlb_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_vlb_dp
// Datapath of the vertex link builder: site and link memories, counters,
// captured request and the response register.
// ----------------------------------------------------------------------------
module sse_vlb_dp #(
  parameter int NUM_SITES  = 256,
  parameter int MAX_SLICES = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire sse_vlb_pkg::cmd_t                   cmd,
  output sse_vlb_pkg::stat_t                       stat,
  input  wire logic                                req_valid,
  input  wire logic [sse_vlb_pkg::OPW-1:0]         operation,
  input  wire logic signed [sse_vlb_pkg::CODEW-1:0] op_code,
  input  wire logic [sse_vlb_pkg::SITEW-1:0]       site_a,
  input  wire logic [sse_vlb_pkg::SITEW-1:0]       site_b,
  input  wire logic [sse_vlb_pkg::SITEW-1:0]       site_c,
  input  wire logic [sse_vlb_pkg::SITEW-1:0]       site_d,
  input  wire logic [sse_vlb_pkg::LEGAW-1:0]       leg_address,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_ready,
  output logic [sse_vlb_pkg::LEGAW-1:0]            link_leg,
  output logic                                     link_present,
  output logic [sse_vlb_pkg::CNTW-1:0]             slices_seen,
  output logic [sse_vlb_pkg::CNTW-1:0]             nonnull_count,
  output logic [sse_vlb_pkg::ENTW-1:0]             link_entries,
  output logic                                     status
);
  import sse_vlb_pkg::*;

  localparam int LEG_CAP = MAX_SLICES * (2 ** LEG_BITS);
  localparam int SLW     = $clog2(MAX_SLICES);
  localparam int LEGW    = SLW + LEG_BITS;
  localparam int SCW     = $clog2(MAX_SLICES + 1);
  localparam int ECW     = $clog2(LEG_CAP + 1);
  localparam int SW      = $clog2(NUM_SITES);
  localparam int SWEEP_N = (LEG_CAP > NUM_SITES) ? LEG_CAP : NUM_SITES;
  localparam int CW      = $clog2(SWEEP_N);

  op_t                     op_r;
  logic signed [CODEW-1:0] code_r;
  logic [SITEW-1:0]        site_r [4];
  logic [LEGAW-1:0]        addr_r;
  logic [1:0]              i_r;
  logic [SW-1:0]           j_r;
  logic [LEGW-1:0]         x_r, y_r;
  logic [SCW-1:0]          slice_cnt, oper_cnt;
  logic [ECW-1:0]          entry_cnt;
  logic [CW-1:0]           sweep_cnt;

  logic                    site_we, site_re, link_we, link_re;
  logic [SW-1:0]           site_waddr, site_addr;
  logic [2*LEGW:0]         site_wdata, site_rdata;
  logic [LEGW-1:0]         link_waddr, link_raddr, link_addr, link_tgt;
  logic [LEGW:0]           link_wdata, link_rdata;
  logic [SITEW-1:0]        cur_site;
  logic [LEGW-1:0]         lower, upper, old_first, old_last;
  logic                    is_close, bond, read_ok, app_ok, is_clear;
  logic [SCW-1:0]          slice_n, oper_n;

  assign is_close  = (op_r == OP_CLOSE);
  assign is_clear  = (op_r == OP_CLEAR);
  assign cur_site  = site_r[i_r];
  assign site_addr = is_close ? j_r : SW'(cur_site);
  assign bond      = (code_r == 4'sd1) || (code_r == -4'sd1);
  assign lower     = {slice_cnt[SLW-1:0], 1'b0, i_r};
  assign upper     = {slice_cnt[SLW-1:0], 1'b1, i_r};
  assign old_first = site_rdata[2*LEGW-1:LEGW];
  assign old_last  = site_rdata[LEGW-1:0];
  assign read_ok   = (32'(addr_r) < LEG_CAP);
  assign link_addr = cmd.link_sel ? y_r : x_r;
  assign link_tgt  = cmd.link_sel ? x_r : y_r;

  assign stat.op         = op_r;
  assign stat.full       = (slice_cnt >= SCW'(MAX_SLICES));
  assign stat.nonnull    = (code_r != '0);
  assign stat.site_ok    = is_close || (32'(cur_site) < NUM_SITES);
  assign stat.last_site  = is_close ? (j_r == SW'(NUM_SITES - 1))
                                    : (i_r == (bond ? 2'd1 : 2'd3));
  assign stat.visited    = site_rdata[2*LEGW];
  assign stat.sweep_last = (sweep_cnt == CW'(SWEEP_N - 1));
  assign stat.out_busy   = rsp_valid && !rsp_ready;

  // site memory: sweep clears the visited mark, an append visit rewrites the record
  always_comb begin
    site_we    = 1'b0;
    site_waddr = site_addr;
    site_wdata = {1'b1, (stat.visited ? old_first : lower), upper};
    if (cmd.sweep) begin
      site_we    = (32'(sweep_cnt) < NUM_SITES);
      site_waddr = SW'(sweep_cnt);
      site_wdata = '0;
    end else if (cmd.site_upd && !is_close) begin
      site_we = 1'b1;
    end
  end
  assign site_re = cmd.site_rd;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = link_addr;
    link_wdata = {1'b1, link_tgt};
    if (cmd.sweep) begin
      link_we    = (32'(sweep_cnt) < LEG_CAP);
      link_waddr = LEGW'(sweep_cnt);
      link_wdata = '0;
    end else if (cmd.link_wr) begin
      link_we = 1'b1;
    end
  end
  assign link_re    = cmd.link_rd || cmd.read_rd;
  assign link_raddr = cmd.read_rd ? LEGW'(addr_r) : link_addr;

  sse_vlb_ram #(.WIDTH(2*LEGW+1), .DEPTH(NUM_SITES)) u_site_ram (
    .clk(clk), .we(site_we), .waddr(site_waddr), .wdata(site_wdata),
    .re(site_re), .raddr(site_addr), .rdata(site_rdata)
  );

  sse_vlb_ram #(.WIDTH(LEGW+1), .DEPTH(LEG_CAP)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
  );

  assign app_ok  = (op_r == OP_APPEND) && !stat.full;
  assign slice_n = slice_cnt + SCW'(app_ok);
  assign oper_n  = oper_cnt + SCW'(app_ok && stat.nonnull);

  // captured request and walk indexes
  always_ff @(posedge clk) begin
    if (cmd.take && req_valid) begin
      op_r      <= op_t'(operation);
      code_r    <= op_code;
      site_r[0] <= site_a;
      site_r[1] <= site_b;
      site_r[2] <= site_c;
      site_r[3] <= site_d;
      addr_r    <= leg_address;
      i_r       <= '0;
      j_r       <= '0;
    end else if (cmd.next_site) begin
      if (is_close) j_r <= j_r + 1'b1;
      else i_r <= i_r + 2'd1;
    end
    if (cmd.site_upd) begin
      x_r <= old_last;
      y_r <= is_close ? old_first : lower;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_cnt <= '0;
      oper_cnt  <= '0;
      entry_cnt <= '0;
      sweep_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= stat.sweep_last ? '0 : sweep_cnt + 1'b1;
      end
      // count an entry only when it goes from empty to filled
      if (cmd.link_wr && !link_rdata[LEGW]) begin
        entry_cnt <= entry_cnt + 1'b1;
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
        if (is_clear) begin
          slice_cnt <= '0;
          oper_cnt  <= '0;
          entry_cnt <= '0;
        end else begin
          slice_cnt <= slice_n;
          oper_cnt  <= oper_n;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if ((op_r == OP_READ) && read_ok && link_rdata[LEGW]) begin
        link_leg     <= LEGAW'(link_rdata[LEGW-1:0]);
        link_present <= 1'b1;
      end else begin
        link_leg     <= '0;
        link_present <= 1'b0;
      end
      slices_seen   <= is_clear ? '0 : CNTW'(slice_n);
      nonnull_count <= is_clear ? '0 : CNTW'(oper_n);
      link_entries  <= is_clear ? '0 : ENTW'(entry_cnt);
      status        <= (op_r == OP_APPEND) && stat.full;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sse_vertex_link_builder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_vertex_link_builder
// Builds the doubly linked vertex-leg list of an operator string, one slice
// per append, with close, read and clear operations.
// ----------------------------------------------------------------------------
//  channel | role   | transaction
//  req     | sink   | operation, op_code, site_a..site_d, leg_address
//  rsp     | source | link_leg, link_present, slices_seen, nonnull_count,
//          |        | link_entries, status
//
//  Append visits each of its sites with a site read and check, and adds link
//  read-modify-writes for each revisited site; close visits every site and
//  does the same for each visited one; read, null and full appends skip the
//  walk. Every visit is a serial read-modify-write through a registered read.
//  Clear answers first, then sweeps the memories over max(MAX_SLICES*8,
//  NUM_SITES) addresses; reset runs the same sweep first.
//  A stalled rsp holds the sequencer in its last step; req is taken again
//  while the previous transaction waits on rsp.
// ----------------------------------------------------------------------------
module sse_vertex_link_builder #(
  parameter int NUM_SITES  = 256,
  parameter int MAX_SLICES = 1024
) (
  input wire logic    clk,
  input wire logic    rst,
  sse_vlb_req_if.sink req,
  sse_vlb_rsp_if.source rsp
);
  import sse_vlb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign req.ready = cmd.take;

  sse_vlb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .stat(stat), .cmd(cmd)
  );

  sse_vlb_dp #(.NUM_SITES(NUM_SITES), .MAX_SLICES(MAX_SLICES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .req_valid(req.valid), .operation(req.operation), .op_code(req.op_code),
    .site_a(req.site_a), .site_b(req.site_b), .site_c(req.site_c),
    .site_d(req.site_d), .leg_address(req.leg_address),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .link_leg(rsp.link_leg),
    .link_present(rsp.link_present), .slices_seen(rsp.slices_seen),
    .nonnull_count(rsp.nonnull_count), .link_entries(rsp.link_entries),
    .status(rsp.status)
  );
endmodule
`default_nettype wire

// ----- hdl/sse_vlb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_vlb_checker
// Port-level checks of the vertex link builder.
// ----------------------------------------------------------------------------
module sse_vlb_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_valid,
  input wire logic                         req_ready,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_ready,
  input wire logic                         link_present,
  input wire logic                         status,
  input wire logic [sse_vlb_pkg::CNTW-1:0] slices_seen,
  input wire logic [sse_vlb_pkg::CNTW-1:0] nonnull_count
);
  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req taken twice in a row");

  a_refused_no_link: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> !link_present)
    else $error("refused append reports a link");

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> nonnull_count <= slices_seen)
    else $error("more operators than slices");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp dropped while stalled");
endmodule

bind sse_vertex_link_builder sse_vlb_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .link_present(rsp.link_present),
  .status(rsp.status), .slices_seen(rsp.slices_seen),
  .nonnull_count(rsp.nonnull_count)
);
`default_nettype wire

// ----- test/sse_vertex_link_builder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_vertex_link_builder_tb
// Self-checking bench: drives clear/append/close/read transactions with random
// gaps and stalls, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module sse_vertex_link_builder_tb;
  import sse_vlb_pkg::*;

  localparam int NSITES   = 256;
  localparam int NSLICES  = 1024;
  localparam int LEG_CAP  = NSLICES * 8;
  localparam int UPPER    = 4;
  localparam int N_RANDOM = 81;

  typedef struct packed {
    logic [LEGAW-1:0] link_leg;
    logic             link_present;
    logic [CNTW-1:0]  slices_seen;
    logic [CNTW-1:0]  nonnull_count;
    logic [ENTW-1:0]  link_entries;
    logic             status;
  } rsp_t;

  typedef struct packed {
    op_t               op;
    logic signed [3:0] code;
    logic [7:0]        sa, sb, sc, sd;
    logic [LEGAW-1:0]  leg;
  } txn_t;

  int errors = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  class link_scoreboard;
    logic [LEGAW-1:0] links[LEG_CAP];
    bit               filled[LEG_CAP];
    bit               visited[NSITES];
    logic [LEGAW-1:0] first_leg[NSITES];
    logic [LEGAW-1:0] last_leg[NSITES];
    int               slices, operators, entries;
    rsp_t             pending[$];
    int               checked;

    function void wipe();
      foreach (filled[i]) filled[i] = 0;
      foreach (visited[i]) visited[i] = 0;
      slices = 0; operators = 0; entries = 0;
    endfunction

    function void put(int leg, int target);
      if (leg >= LEG_CAP) return;
      if (!filled[leg]) begin
        filled[leg] = 1;
        entries++;
      end
      links[leg] = LEGAW'(target);
    endfunction

    function void touch(int site, int slice, int leg);
      int lower;
      lower = slice * 8 + leg;
      if (!visited[site]) begin
        visited[site] = 1;
        first_leg[site] = LEGAW'(lower);
      end else begin
        put(last_leg[site], lower);
        put(lower, last_leg[site]);
      end
      last_leg[site] = LEGAW'(lower + UPPER);
    endfunction

    function void note(txn_t t);
      rsp_t r;
      int n;
      logic [7:0] s[4];
      r = '0;
      s = '{t.sa, t.sb, t.sc, t.sd};
      case (t.op)
        OP_CLEAR: wipe();
        OP_APPEND: begin
          if (slices >= NSLICES) r.status = 1'b1;
          else begin
            if (t.code != 0) begin
              n = (t.code == 1 || t.code == -1) ? 2 : 4;
              operators++;
              for (int i = 0; i < n; i++) touch(s[i], slices, i);
            end
            slices++;
          end
        end
        OP_CLOSE: begin
          for (int i = 0; i < NSITES; i++)
            if (visited[i]) begin
              put(last_leg[i], first_leg[i]);
              put(first_leg[i], last_leg[i]);
            end
        end
        default: begin
          if (t.leg < LEG_CAP && filled[t.leg]) begin
            r.link_leg = links[t.leg];
            r.link_present = 1'b1;
          end
        end
      endcase
      r.slices_seen = CNTW'(slices);
      r.nonnull_count = CNTW'(operators);
      r.link_entries = ENTW'(entries);
      pending.push_back(r);
    endfunction

    task check(rsp_t got);
      rsp_t w;
      if (pending.size() == 0) begin
        report("unexpected response", 0, 0);
        return;
      end
      w = pending.pop_front();
      checked++;
      if (got.link_leg !== w.link_leg) report("link_leg", got.link_leg, w.link_leg);
      if (got.link_present !== w.link_present)
        report("link_present", got.link_present, w.link_present);
      if (got.slices_seen !== w.slices_seen)
        report("slices_seen", got.slices_seen, w.slices_seen);
      if (got.nonnull_count !== w.nonnull_count)
        report("nonnull_count", got.nonnull_count, w.nonnull_count);
      if (got.link_entries !== w.link_entries)
        report("link_entries", got.link_entries, w.link_entries);
      if (got.status !== w.status) report("status", got.status, w.status);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  sse_vlb_req_if req ();
  sse_vlb_rsp_if rsp ();

  sse_vertex_link_builder #(.NUM_SITES(NSITES), .MAX_SLICES(NSLICES)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  link_scoreboard board = new();
  bit stall_free = 0;
  int n_append, n_close, n_read, n_full;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // response side: random stall per response, sampled at rising edge
  initial begin
    int w;
    rsp.ready = 0;
    forever begin
      w = stall_free ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        rsp.ready <= 0;
        repeat (w) @(negedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      board.check(rsp_t'({rsp.link_leg, rsp.link_present, rsp.slices_seen,
                          rsp.nonnull_count, rsp.link_entries, rsp.status}));
      @(negedge clk);
    end
  end

  task automatic send(input txn_t t, input bit gap_ok = 1);
    int w;
    w = (gap_ok && !stall_free) ? $urandom_range(0, 13) : 0;
    @(negedge clk);
    repeat (w) @(negedge clk);
    req.valid <= 1;
    req.operation <= t.op;
    req.op_code <= t.code;
    req.site_a <= t.sa;
    req.site_b <= t.sb;
    req.site_c <= t.sc;
    req.site_d <= t.sd;
    req.leg_address <= t.leg;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note(t);
    case (t.op)
      OP_APPEND: begin
        n_append++;
        if (board.pending[$].status) n_full++;
      end
      OP_CLOSE: n_close++;
      OP_READ: n_read++;
      default: ;
    endcase
    @(negedge clk);
    req.valid <= 0;
  endtask

  function automatic txn_t mk(op_t op, logic signed [3:0] code = 0, int a = 0, int b = 0,
                              int c = 0, int d = 0, int leg = 0);
    txn_t t;
    t.op = op; t.code = code; t.sa = 8'(a); t.sb = 8'(b); t.sc = 8'(c); t.sd = 8'(d);
    t.leg = LEGAW'(leg);
    return t;
  endfunction

  function automatic txn_t rand_txn(int hot_sites);
    txn_t t;
    int p;
    int top;
    p = $urandom_range(0, 99);
    top = hot_sites - 1;
    t = mk(OP_APPEND, 4'($urandom_range(0, 15)), $urandom_range(0, top),
           $urandom_range(0, top), $urandom_range(0, top), $urandom_range(0, top), 0);
    if ($urandom_range(0, 9) == 0) begin
      t.sa = 8'($urandom); t.sb = 8'($urandom); t.sc = 8'($urandom); t.sd = 8'($urandom);
    end
    t.leg = (board.slices > 0) ? LEGAW'($urandom_range(0, board.slices * 8 - 1))
                               : LEGAW'($urandom_range(0, 63));
    if (p < 2) t.op = OP_CLEAR;
    else if (p < 6) t.op = OP_CLOSE;
    else if (p < 30) begin
      t.op = OP_READ;
      if ($urandom_range(0, 7) == 0) t.leg = LEGAW'($urandom);
    end
    return t;
  endfunction

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    int limit;
    req.valid = 0;
    req.operation = OP_CLEAR;
    req.op_code = 0;
    req.site_a = 0; req.site_b = 0; req.site_c = 0; req.site_d = 0;
    req.leg_address = 0;
    board.wipe();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: bonds, plaquettes, null, repeated sites, close, reads, extremes
    send(mk(OP_APPEND, 1, 0, 255));
    send(mk(OP_APPEND, -1, 255, 0));
    send(mk(OP_APPEND, 0, 7, 7, 7, 7));
    send(mk(OP_APPEND, 7, 3, 3, 170, 85));
    send(mk(OP_APPEND, -8, 0, 255, 3, 85));
    send(mk(OP_APPEND, 2, 1, 2, 4, 8));
    send(mk(OP_APPEND, -4, 16, 32, 64, 128));
    send(mk(OP_READ, 0, 0, 0, 0, 0, 0));
    send(mk(OP_READ, 0, 0, 0, 0, 0, 12));
    send(mk(OP_CLOSE));
    send(mk(OP_READ, 0, 0, 0, 0, 0, 4));
    send(mk(OP_CLOSE));
    send(mk(OP_APPEND, 1, 255, 3));
    send(mk(OP_READ, 0, 0, 0, 0, 0, 8191));
    send(mk(OP_READ, 0, 0, 0, 0, 0, LEG_CAP - 1));
    send(mk(OP_READ, 0, 0, 0, 0, 0, 5461));
    send(mk(OP_READ, 0, 0, 0, 0, 0, 2730));
    send(mk(OP_CLEAR));
    send(mk(OP_READ, 0, 0, 0, 0, 0, 4));

    // hold off until all responses are in, then run without idling
    drain();
    stall_free = 1;
    repeat (20) send(rand_txn(8));
    stall_free = 0;

    // fill to capacity with null-heavy appends, then refuse appends
    for (int i = 0; i < NSLICES; i++)
      send(mk(OP_APPEND, ($urandom_range(0, 9) == 0) ? 4'sd1 : 4'sd0,
              $urandom_range(0, 3), $urandom_range(0, 3)), 0);
    send(mk(OP_APPEND, -1, 1, 2));
    send(mk(OP_APPEND, 5, 1, 2, 3, 4));
    send(mk(OP_CLOSE));
    send(mk(OP_READ, 0, 0, 0, 0, 0, LEG_CAP - 4));
    send(mk(OP_READ, 0, 0, 0, 0, 0, LEG_CAP));
    send(mk(OP_CLEAR));

    for (int i = 0; i < N_RANDOM; i++) send(rand_txn((i % 3 == 0) ? 256 : 12));

    drain();
    limit = 0;
    while (board.pending.size() != 0 && limit < 100000) begin
      @(negedge clk);
      limit++;
    end
    repeat (100) @(negedge clk);
    $display("covered %0d appends (%0d refused), %0d closes, %0d reads; %0d responses checked",
             n_append, n_full, n_close, n_read, board.checked);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/sse_vlb_pkg.sv
hdl/sse_vlb_if.sv
hdl/sse_vlb_ram.sv
hdl/sse_vlb_ctrl.sv
hdl/sse_vlb_dp.sv
hdl/sse_vertex_link_builder.sv
hdl/sse_vlb_checker.sv
test/sse_vertex_link_builder_tb.sv
